// ===== rtl/dpt_pkg.sv =====
// Package: shared types, status codes and controller states for the page translator
`timescale 1ns / 1ps
package dpt_pkg;

  localparam int VA_W = 17;
  localparam int PA_W = 16;
  localparam int ST_W = 2;

  localparam logic [ST_W-1:0] STATUS_HIT  = 2'd0;
  localparam logic [ST_W-1:0] STATUS_NEW  = 2'd1;
  localparam logic [ST_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic            process_select;
    logic [VA_W-1:0] virtual_address;
  } access_t;

  typedef struct packed {
    logic [PA_W-1:0] physical_address;
    logic [ST_W-1:0] status;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_LOOKUP,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic reduce;
    logic lookup;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic reduce_done;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/dpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module dpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/dpt_ctrl.sv =====
// Controller: sequences page map clearing, page reduction, lookup and commit
`timescale 1ns / 1ps
module dpt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          access_valid,
  output logic          access_ready,
  input  dpt_pkg::stat_t stat,
  output dpt_pkg::cmd_t  cmd
);

  dpt_pkg::state_t state;
  dpt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    access_ready = 1'b0;
    unique case (state)
      dpt_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = dpt_pkg::ST_IDLE;
        end
      end
      dpt_pkg::ST_IDLE: begin
        access_ready = 1'b1;
        if (access_valid) begin
          cmd.load   = 1'b1;
          state_next = dpt_pkg::ST_REDUCE;
        end
      end
      dpt_pkg::ST_REDUCE: begin
        cmd.reduce = 1'b1;
        if (stat.reduce_done) begin
          state_next = dpt_pkg::ST_LOOKUP;
        end
      end
      dpt_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = dpt_pkg::ST_CHECK;
      end
      dpt_pkg::ST_CHECK: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = dpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dpt_pkg::ST_IDLE;
      end
    endcase
  end

  a_check_holds: assert property (@(posedge clk) disable iff (rst)
    (state == dpt_pkg::ST_CHECK) && !stat.out_free |=> state == dpt_pkg::ST_CHECK)
    else $error("commit stage left while result register was blocked");

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    (state != dpt_pkg::ST_CLEAR) |=> state != dpt_pkg::ST_CLEAR)
    else $error("clearing pass re-entered outside reset");

endmodule

// ===== rtl/dpt_datapath.sv =====
// Datapath: page number reduction, page map memory, frame allocation and result register
`timescale 1ns / 1ps
module dpt_datapath #(
  parameter int PAGE_SIZE     = 4096,
  parameter int FRAME_COUNT   = 16,
  parameter int PAGE_COUNT    = 32,
  parameter int PROCESS_COUNT = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  dpt_pkg::cmd_t    cmd,
  output dpt_pkg::stat_t   stat,
  input  dpt_pkg::access_t access,
  output logic             result_valid,
  input  logic             result_ready,
  output dpt_pkg::result_t result
);

  localparam int OFF_W = $clog2(PAGE_SIZE);
  localparam int PN_W  = dpt_pkg::VA_W - OFF_W;
  localparam int PG_W  = $clog2(PAGE_COUNT);
  localparam int FR_W  = $clog2(FRAME_COUNT);
  localparam int CW    = $clog2(FRAME_COUNT + 1);
  localparam int DEPTH = PROCESS_COUNT * PAGE_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = FR_W + 1;
  localparam int RS    = PN_W + PG_W;
  localparam int MW    = PN_W + 2;
  localparam int PW    = PN_W + MW;
  localparam longint RECIP = ((longint'(1) << RS) + longint'(PAGE_COUNT) - 1)
                             / longint'(PAGE_COUNT);

  logic             proc;
  logic [PN_W-1:0]  pn;
  logic [OFF_W-1:0] offset;
  logic [PG_W-1:0]  rem;
  logic [PN_W-1:0]  quot;
  logic             step;
  logic [AW-1:0]    clr_cnt;
  logic [CW-1:0]    alloc_cnt;

  logic [PW-1:0]    quot_prod;
  logic [PN_W-1:0]  quot_next;
  logic [RS-1:0]    back;
  logic [PG_W-1:0]  rem_next;
  logic [AW-1:0]    slot;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [EW-1:0]    wr_data;
  logic [EW-1:0]    rd_data;
  logic             hit;
  logic             has_free;
  logic [FR_W-1:0]  frame;
  logic [31:0]      pa_full;
  dpt_pkg::result_t result_next;

  assign quot_prod = PW'(pn) * PW'(RECIP);
  assign quot_next = PN_W'(quot_prod >> RS);
  assign back      = RS'(quot) * RS'(PAGE_COUNT);
  assign rem_next  = PG_W'(RS'(pn) - back);

  assign slot     = proc ? AW'(PAGE_COUNT) + AW'(rem) : AW'(rem);
  assign hit      = rd_data[EW-1];
  assign has_free = alloc_cnt < CW'(FRAME_COUNT);
  assign frame    = hit ? rd_data[FR_W-1:0] : alloc_cnt[FR_W-1:0];
  assign pa_full  = (32'(frame) << OFF_W) | 32'(offset);

  always_comb begin
    priority if (hit) begin
      result_next.physical_address = pa_full[dpt_pkg::PA_W-1:0];
      result_next.status           = dpt_pkg::STATUS_HIT;
    end else if (has_free) begin
      result_next.physical_address = pa_full[dpt_pkg::PA_W-1:0];
      result_next.status           = dpt_pkg::STATUS_NEW;
    end else begin
      result_next.physical_address = '0;
      result_next.status           = dpt_pkg::STATUS_FULL;
    end
  end

  assign wr_en   = cmd.clear || (cmd.commit && !hit && has_free);
  assign wr_addr = cmd.clear ? clr_cnt : slot;
  assign wr_data = cmd.clear ? '0 : {1'b1, alloc_cnt[FR_W-1:0]};

  assign stat.clear_done  = clr_cnt == AW'(DEPTH - 1);
  assign stat.reduce_done = step;
  assign stat.out_free    = !result_valid || result_ready;

  dpt_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_page_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.lookup),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      alloc_cnt    <= '0;
      step         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.load) begin
        step <= 1'b0;
      end else if (cmd.reduce) begin
        step <= 1'b1;
      end
      if (cmd.commit && !hit && has_free) begin
        alloc_cnt <= alloc_cnt + CW'(1);
      end
      if (cmd.commit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      proc   <= (PROCESS_COUNT > 1) ? access.process_select : 1'b0;
      pn     <= access.virtual_address[dpt_pkg::VA_W-1:OFF_W];
      offset <= access.virtual_address[OFF_W-1:0];
    end else if (cmd.reduce) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
    if (cmd.commit) begin
      result <= result_next;
    end
  end

  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    alloc_cnt <= CW'(FRAME_COUNT))
    else $error("frame allocation count beyond frame count");

  a_alloc_step: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && !hit && has_free |=>
      alloc_cnt == $past(alloc_cnt) + CW'(1) && result.status == dpt_pkg::STATUS_NEW)
    else $error("new mapping did not claim exactly one frame");

  a_fault: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && !hit && !has_free |=>
      $stable(alloc_cnt) && result.status == dpt_pkg::STATUS_FULL &&
      result.physical_address == '0)
    else $error("fault transaction changed allocation or returned an address");

endmodule

// ===== rtl/demand_paging_translator.sv =====
// Top level: demand paging address translator with per-process page tables
//
//  channel  direction  handshake                    payload
//  access   in         access_valid/access_ready    dpt_pkg::access_t
//  result   out        result_valid/result_ready    dpt_pkg::result_t
//
// Each transaction goes through acceptance, the page number reduction (reciprocal multiply
// for the quotient, then the remainder), a page map read and a commit.
// After reset a clearing pass writes every page map entry, with access_ready low.
// A held result stalls the commit cycle; access_ready stays low until the commit.
`timescale 1ns / 1ps
module demand_paging_translator #(
  parameter int PAGE_SIZE     = 4096,
  parameter int FRAME_COUNT   = 16,
  parameter int PAGE_COUNT    = 32,
  parameter int PROCESS_COUNT = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             access_valid,
  output logic             access_ready,
  input  dpt_pkg::access_t access,
  output logic             result_valid,
  input  logic             result_ready,
  output dpt_pkg::result_t result
);

  dpt_pkg::cmd_t  cmd;
  dpt_pkg::stat_t stat;

  dpt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .access_valid (access_valid),
    .access_ready (access_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  dpt_datapath #(
    .PAGE_SIZE     (PAGE_SIZE),
    .FRAME_COUNT   (FRAME_COUNT),
    .PAGE_COUNT    (PAGE_COUNT),
    .PROCESS_COUNT (PROCESS_COUNT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .access       (access),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== verif/demand_paging_translator_test.sv =====
// Testbench: checks the page translator against a predictor under random bursts and stalls
`timescale 1ns / 1ps
module demand_paging_translator_test;

  localparam int OFFSET_W     = 12;
  localparam int FRAMES       = 16;
  localparam int PAGES        = 32;
  localparam int SLOTS        = 2 * PAGES;
  localparam int RANDOM_ITEMS = 1330;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    dpt_pkg::access_t acc;
    bit               typed;
    dpt_pkg::result_t want;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             access_valid = 1'b0;
  logic             access_ready;
  dpt_pkg::access_t access = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  dpt_pkg::result_t result;

  plan_row_t         access_plan[$];
  dpt_pkg::result_t  expected_translations[$];
  int                mapped_slots[$];
  logic              slot_mapped[SLOTS];
  logic [3:0]        slot_frame[SLOTS];
  logic [FRAMES-1:0] frames_taken;
  int                failures = 0;
  int                loaded = 0;
  int                accepted = 0;
  int                idle_cycles = 0;

  demand_paging_translator u_dut (
    .clk          (clk),
    .rst          (rst),
    .access_valid (access_valid),
    .access_ready (access_ready),
    .access       (access),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic dpt_pkg::result_t translate_access(dpt_pkg::access_t a);
    logic [4:0]          page;
    logic [OFFSET_W-1:0] offset;
    logic [3:0]          frame;
    int                  slot;
    bit                  found;
    dpt_pkg::result_t    r;
    page   = a.virtual_address[16:OFFSET_W];
    offset = a.virtual_address[OFFSET_W-1:0];
    slot   = a.process_select * PAGES + page;
    found  = 1'b0;
    frame  = '0;
    if (slot_mapped[slot]) begin
      frame    = slot_frame[slot];
      r.status = dpt_pkg::STATUS_HIT;
    end else begin
      for (int f = 0; f < FRAMES; f++) begin
        if (!found && !frames_taken[f]) begin
          frame = 4'(f);
          found = 1'b1;
        end
      end
      if (!found) begin
        r.physical_address = '0;
        r.status           = dpt_pkg::STATUS_FULL;
        return r;
      end
      frames_taken[frame] = 1'b1;
      slot_mapped[slot]   = 1'b1;
      slot_frame[slot]    = frame;
      mapped_slots.push_back(slot);
      r.status = dpt_pkg::STATUS_NEW;
    end
    r.physical_address = {frame, offset};
    return r;
  endfunction

  function automatic plan_row_t make_row(bit proc, logic [16:0] va, bit typed,
                                         logic [15:0] pa, logic [1:0] st);
    plan_row_t row;
    row.acc.process_select  = proc;
    row.acc.virtual_address = va;
    row.typed               = typed;
    row.want.physical_address = pa;
    row.want.status           = st;
    return row;
  endfunction

  function automatic plan_row_t random_row();
    plan_row_t           row;
    int                  slot;
    logic [4:0]          page;
    logic [OFFSET_W-1:0] offset;
    case ($urandom_range(0, 3))
      0:       offset = '0;
      1:       offset = '1;
      default: offset = OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1));
    endcase
    row.typed = 1'b0;
    row.want  = '0;
    if (mapped_slots.size() != 0 && $urandom_range(0, 99) < 65) begin
      slot = mapped_slots[$urandom_range(0, mapped_slots.size() - 1)];
      page = 5'(slot % PAGES);
      row.acc.process_select  = 1'(slot / PAGES);
      row.acc.virtual_address = {page, offset};
    end else begin
      row.acc.process_select  = 1'($urandom_range(0, 1));
      row.acc.virtual_address = 17'($urandom_range(0, 17'h1FFFF));
    end
    return row;
  endfunction

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      slot_mapped[s] = 1'b0;
      slot_frame[s]  = '0;
    end
    frames_taken = '0;
    access_plan.push_back(make_row(1'b0, 17'h00000, 1'b1, 16'h0000, dpt_pkg::STATUS_NEW));
    access_plan.push_back(make_row(1'b1, 17'h1FFFF, 1'b1, 16'h1FFF, dpt_pkg::STATUS_NEW));
    access_plan.push_back(make_row(1'b1, 17'h1FFFF, 1'b1, 16'h1FFF, dpt_pkg::STATUS_HIT));
    access_plan.push_back(make_row(1'b0, 17'h00FFF, 1'b0, '0, '0));
    access_plan.push_back(make_row(1'b1, 17'h00000, 1'b0, '0, '0));
    for (int p = 1; p <= 13; p++) begin
      access_plan.push_back(make_row(1'b0, 17'((p << OFFSET_W) | ((p * 'h123) & 'hFFF)),
                                     1'b0, '0, '0));
    end
    access_plan.push_back(make_row(1'b0, 17'h1F000, 1'b1, 16'h0000, dpt_pkg::STATUS_FULL));
    access_plan.push_back(make_row(1'b1, 17'h10ABC, 1'b1, 16'h0000, dpt_pkg::STATUS_FULL));
    access_plan.push_back(make_row(1'b0, 17'h0D555, 1'b0, '0, '0));
    access_plan.push_back(make_row(1'b1, 17'h1F000, 1'b0, '0, '0));
    access_plan.push_back(make_row(1'b0, 17'h0AAAA, 1'b0, '0, '0));
  end

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk) begin : drive_access
    int               burst_left;
    int               gap_left;
    plan_row_t        row;
    dpt_pkg::result_t predicted;
    if (rst) begin
      access_valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else if (!access_valid || access_ready) begin
      if (access_valid) begin
        predicted = translate_access(access);
        expected_translations.push_back(row.typed ? row.want : predicted);
        accepted++;
      end
      if (gap_left > 0) begin
        gap_left--;
        access_valid <= 1'b0;
      end else if (loaded < access_plan.size() + RANDOM_ITEMS) begin
        row = (loaded < access_plan.size()) ? access_plan[loaded] : random_row();
        access       <= row.acc;
        access_valid <= 1'b1;
        loaded++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        access_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern is redrawn at random once per window
  always @(posedge clk) begin : drive_ready
    int   window_cycle;
    int   mode;
    logic ready_next;
    if (rst) begin
      window_cycle = 0;
      mode         = 0;
      result_ready <= 1'b0;
    end else begin
      if (window_cycle == 49) begin
        window_cycle = 0;
        mode         = $urandom_range(0, 3);
      end else begin
        window_cycle++;
      end
      case (mode)
        0:       ready_next = 1'b1;
        1:       ready_next = 1'($urandom_range(0, 1));
        2:       ready_next = (window_cycle % 4) == 0;
        default: ready_next = $urandom_range(0, 7) != 0;
      endcase
      result_ready <= ready_next;
    end
  end

  always @(posedge clk) begin : check_translation
    dpt_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_translations.size() == 0) begin
        $display("%0t: unexpected transaction physical_address=%h status=%0d",
                 $time, result.physical_address, result.status);
        failures++;
      end else begin
        want = expected_translations.pop_front();
        if (result.physical_address !== want.physical_address) begin
          $display("%0t: physical_address expected %h actual %h",
                   $time, want.physical_address, result.physical_address);
          failures++;
        end
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, result.status);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((access_valid && access_ready) || (result_valid && result_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (accepted < access_plan.size() + RANDOM_ITEMS) @(posedge clk);
    while (expected_translations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && expected_translations.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
